/* hw/rtl/bit_column_stream_compactor_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bit column stream compactor
// Shared wrappers that clock on clk; one variant is gated off during reset.
// ----------------------------------------------------------------------------
`ifndef BIT_COLUMN_STREAM_COMPACTOR_ASSERT_SVH
`define BIT_COLUMN_STREAM_COMPACTOR_ASSERT_SVH

// Checked only while the block is out of reset.
`define BCSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bcsc assertion failed");

// Checked at every edge, including those with reset high.
`define BCSC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bcsc reset assertion failed");

`endif

/* hw/rtl/bcsc_pkg.sv */
// ----------------------------------------------------------------------------
// Bit column stream compactor package
// Shared widths, register indexes and the structs passed between modules.
// ----------------------------------------------------------------------------
package bcsc_pkg;

  localparam int WORD_W        = 64;
  localparam int FILL_W        = 6;
  localparam int NCNT_W        = 7;
  localparam int CFG_W         = 13;
  localparam int CFG_IDX_W     = 4;
  localparam int MAX_SHOTS_DEF = 4096;
  localparam int OUT_DEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LIVE_SHOTS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_KEPT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] LIVE_SHOTS_RST    = CFG_W'(64);
  localparam logic [CFG_W-1:0] EXPECTED_KEPT_RST = CFG_W'(0);

  typedef struct packed {
    logic [CFG_W-1:0] live_shots;
    logic [CFG_W-1:0] expected_kept;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              final_word;
    logic              count_mismatch;
  } result_t;

  // Up to two results leave the packer for one column word.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

/* hw/rtl/bcsc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// Holds live_shots and expected_kept, written through the config channel.
// ----------------------------------------------------------------------------
module bcsc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcsc_pkg::CFG_W-1:0]     cfg_data,
  output bcsc_pkg::cfg_t                 cfg
);

  logic wr_en;

  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.live_shots    <= bcsc_pkg::LIVE_SHOTS_RST;
      cfg.expected_kept <= bcsc_pkg::EXPECTED_KEPT_RST;
    end else if (wr_en) begin
      unique case (cfg_index)
        bcsc_pkg::REG_LIVE_SHOTS:    cfg.live_shots    <= cfg_data;
        bcsc_pkg::REG_EXPECTED_KEPT: cfg.expected_kept <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/bcsc_pext.sv */
// ----------------------------------------------------------------------------
// Parallel bit extract
// Packs the source bits selected by the mask toward bit 0, lowest first.
// ----------------------------------------------------------------------------
module bcsc_pext (
  input  logic [bcsc_pkg::WORD_W-1:0] src,
  input  logic [bcsc_pkg::WORD_W-1:0] mask,
  output logic [bcsc_pkg::WORD_W-1:0] ext,
  output logic [bcsc_pkg::NCNT_W-1:0] n
);

  localparam int W  = bcsc_pkg::WORD_W;
  localparam int SW = $clog2(bcsc_pkg::WORD_W);

  logic [W-1:0]  val [0:SW];
  logic [W-1:0]  occ [0:SW];
  logic [SW-1:0] sh  [0:SW][0:W-1];

  // Each kept bit moves down by the number of dropped bits below it. Moving
  // by the distance bits lowest first never lets two bits land on one slot.
  always_comb begin
    int   hi;
    logic from_hi;
    logic stay;
    for (int j = 0; j < W; j++) begin
      val[0][j] = src[j];
      occ[0][j] = mask[j];
      sh[0][j]  = SW'($countones(~mask & ((64'd1 << j) - 64'd1)));
    end
    for (int k = 0; k < SW; k++) begin
      for (int j = 0; j < W; j++) begin
        hi      = j + (1 << k);
        from_hi = 1'b0;
        if (hi < W) begin
          from_hi = occ[k][hi[SW-1:0]] && sh[k][hi[SW-1:0]][k];
        end
        stay = occ[k][j] && !sh[k][j][k];
        if (from_hi) begin
          val[k+1][j] = val[k][hi[SW-1:0]];
          sh[k+1][j]  = sh[k][hi[SW-1:0]];
        end else begin
          val[k+1][j] = val[k][j];
          sh[k+1][j]  = sh[k][j];
        end
        occ[k+1][j] = from_hi || stay;
      end
    end
  end

  assign ext = val[SW] & occ[SW];
  assign n   = bcsc_pkg::NCNT_W'($countones(mask));

endmodule

/* hw/rtl/bcsc_packer.sv */
// ----------------------------------------------------------------------------
// Column packer
// Input register, live-shot masking, bit extract and append to the partial
// output word; produces zero, one or two results per column word.
// ----------------------------------------------------------------------------
module bcsc_packer #(
  parameter int MAX_SHOTS = bcsc_pkg::MAX_SHOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bcsc_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [bcsc_pkg::WORD_W-1:0] column_word,
  input  logic [bcsc_pkg::WORD_W-1:0] keep_flags,
  input  logic                        room,
  output bcsc_pkg::push_t             push
);

  localparam int W       = bcsc_pkg::WORD_W;
  localparam int FW      = bcsc_pkg::FILL_W;
  localparam int NW      = bcsc_pkg::NCNT_W;
  localparam int CW      = bcsc_pkg::CFG_W;
  localparam int SHB     = $clog2(MAX_SHOTS + 1);
  localparam int SH_W    = (SHB > CW) ? SHB : CW;
  localparam int LIDX_W  = SH_W - FW;
  localparam int NWORDS  = (MAX_SHOTS + W - 1) / W;
  localparam int WPOS_W  = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int KC_W    = SHB;
  localparam int CMP_W   = (KC_W > CW) ? KC_W : CW;

  // Input register
  logic         s1_valid;
  logic [W-1:0] s1_word;
  logic [W-1:0] s1_keep;
  logic         fire;

  // Stream state
  logic [W-1:0]      partial_word;
  logic [FW-1:0]     fill_count;
  logic [WPOS_W-1:0] word_position;
  logic [KC_W-1:0]   kept_count;

  logic [SH_W-1:0]   ls_ext;
  logic [SH_W-1:0]   shots;
  logic [LIDX_W-1:0] last_idx;
  logic              is_last;
  logic [FW-1:0]     rem;
  logic [W-1:0]      live;
  logic [W-1:0]      keep;
  logic [W-1:0]      ext;
  logic [NW-1:0]     n;
  logic [NW-1:0]     total;
  logic              full;
  logic [W-1:0]      shifted;
  logic [W-1:0]      partial_next;
  logic [FW-1:0]     fill_next;
  logic [KC_W-1:0]   kept_next;
  logic              mismatch;
  bcsc_pkg::result_t flush;
  bcsc_pkg::push_t   push_c;

  assign fire     = s1_valid && room;
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_word <= column_word;
      s1_keep <= keep_flags;
    end
  end

  // Out-of-range live_shots is clamped to 1..MAX_SHOTS.
  always_comb begin
    ls_ext = SH_W'(cfg.live_shots);
    if (ls_ext == '0) begin
      shots = SH_W'(1);
    end else if (ls_ext > SH_W'(MAX_SHOTS)) begin
      shots = SH_W'(MAX_SHOTS);
    end else begin
      shots = ls_ext;
    end
  end

  assign last_idx = LIDX_W'((shots - SH_W'(1)) >> FW);
  assign is_last  = LIDX_W'(word_position) >= last_idx;
  assign rem      = shots[FW-1:0];
  assign live     = (is_last && rem != '0) ? ((64'd1 << rem) - 64'd1) : '1;
  assign keep     = s1_keep & live;

  bcsc_pext u_pext (
    .src  (s1_word),
    .mask (keep),
    .ext  (ext),
    .n    (n)
  );

  assign total     = NW'(fill_count) + n;
  assign full      = total[NW-1];
  assign shifted   = ext << fill_count;
  assign fill_next = total[FW-1:0];
  assign kept_next = kept_count + KC_W'(n);
  assign mismatch  = CMP_W'(kept_next) != CMP_W'(cfg.expected_kept);

  always_comb begin
    if (full) begin
      partial_next = (fill_count == '0) ? '0 : (ext >> (NW'(W) - NW'(fill_count)));
    end else begin
      partial_next = partial_word | shifted;
    end
  end

  always_comb begin
    push_c                = '0;
    flush.packed_word     = (fill_next != '0) ? partial_next : '0;
    flush.final_word      = 1'b1;
    flush.count_mismatch  = mismatch;
    if (full) begin
      push_c.cnt            = 2'd1;
      push_c.r0.packed_word = partial_word | shifted;
    end
    if (is_last) begin
      if (fill_next != '0 || !full) begin
        // The remainder, or an empty zero word, carries the final mark.
        if (full) begin
          push_c.r1  = flush;
          push_c.cnt = 2'd2;
        end else begin
          push_c.r0  = flush;
          push_c.cnt = 2'd1;
        end
      end else begin
        push_c.r0.final_word     = 1'b1;
        push_c.r0.count_mismatch = mismatch;
      end
    end
  end

  always_comb begin
    push = push_c;
    if (!fire) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_word  <= '0;
      fill_count    <= '0;
      word_position <= '0;
      kept_count    <= '0;
    end else if (fire) begin
      if (is_last) begin
        partial_word  <= '0;
        fill_count    <= '0;
        word_position <= '0;
        kept_count    <= '0;
      end else begin
        partial_word  <= partial_next;
        fill_count    <= fill_next;
        word_position <= word_position + WPOS_W'(1);
        kept_count    <= kept_next;
      end
    end
  end

endmodule

/* hw/rtl/bcsc_out_fifo.sv */
// ----------------------------------------------------------------------------
// Result queue
// Small queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module bcsc_out_fifo (
  input  logic                        clk,
  input  logic                        rst,
  input  bcsc_pkg::push_t             push,
  output logic                        room,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bcsc_pkg::WORD_W-1:0] packed_word,
  output logic                        final_word,
  output logic                        count_mismatch
);

  localparam int DEPTH = bcsc_pkg::OUT_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CF_W  = $clog2(DEPTH + 1);

  bcsc_pkg::result_t mem [0:DEPTH-1];

  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CF_W-1:0]  count;
  logic             pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;

  // Room for the worst case of two results, counting a slot freed this cycle.
  assign room = ((CF_W + 1)'(count) + (CF_W + 1)'(2)) <=
                ((CF_W + 1)'(DEPTH) + (CF_W + 1)'(pop));

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wptr] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem[wptr + PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + PTR_W'(push.cnt);
      rptr  <= rptr + PTR_W'(pop);
      count <= count + CF_W'(push.cnt) - CF_W'(pop);
    end
  end

  assign packed_word    = mem[rptr].packed_word;
  assign final_word     = mem[rptr].final_word;
  assign count_mismatch = mem[rptr].count_mismatch;

endmodule

/* hw/rtl/bit_column_stream_compactor.sv */
// ----------------------------------------------------------------------------
// Bit column stream compactor
// Drops the shots whose keep flag is clear and packs the survivors of a
// column into dense 64-bit words, flagging the column's final word.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests carry one 64-bit column word and its keep flags on
//   in_valid/in_ready. Result requests carry packed_word, final_word and
//   count_mismatch on out_valid/out_ready. The config channel
//   (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready; write it
//   only while no column word is in flight.
//   A column word accepted on the input is held in the input register,
//   then extracted and appended as it is written into the result queue,
//   from which its first result is offered on the output.
//   One column word is taken per cycle while the result queue has room. A
//   word that completes a packed word and also ends the column yields two
//   results, which the single output port hands out one at a time.
//   A four-entry result queue sits between the packer and the output, so
//   input requests keep flowing while a result waits; when the receiver
//   stalls and the queue cannot take two more results, in_ready drops.
//   Reset empties the queue, clears the partial word and the column
//   position, and sets live_shots to 64 and expected_kept to 0.
// ----------------------------------------------------------------------------
module bit_column_stream_compactor #(
  parameter int MAX_SHOTS = bcsc_pkg::MAX_SHOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [bcsc_pkg::WORD_W-1:0]    column_word,
  input  logic [bcsc_pkg::WORD_W-1:0]    keep_flags,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bcsc_pkg::WORD_W-1:0]    packed_word,
  output logic                           final_word,
  output logic                           count_mismatch,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bcsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bcsc_pkg::CFG_W-1:0]     cfg_data
);

  bcsc_pkg::cfg_t  cfg;
  bcsc_pkg::push_t push;
  logic            room;

  bcsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bcsc_packer #(
    .MAX_SHOTS (MAX_SHOTS)
  ) u_packer (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .column_word (column_word),
    .keep_flags  (keep_flags),
    .room        (room),
    .push        (push)
  );

  bcsc_out_fifo u_out (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .room           (room),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .packed_word    (packed_word),
    .final_word     (final_word),
    .count_mismatch (count_mismatch)
  );

endmodule

/* hw/rtl/bcsc_checker.sv */
// ----------------------------------------------------------------------------
// Port checker for the bit column stream compactor
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
`include "bit_column_stream_compactor_assert.svh"

module bcsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bcsc_pkg::WORD_W-1:0] packed_word,
  input logic                        final_word,
  input logic                        count_mismatch
);

  // A stalled result must hold its value.
  `BCSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(packed_word) && $stable(final_word) && $stable(count_mismatch))

  // The count check is only reported on the column's final word.
  `BCSC_ASSERT(a_mismatch_final, out_valid && !final_word |-> !count_mismatch)

  // Reset leaves the queue empty and the input open.
  `BCSC_ASSERT_RST(a_reset_idle, rst |=> !out_valid && in_ready)

endmodule

bind bit_column_stream_compactor bcsc_checker u_bcsc_checker (.*);

/* tb/bit_column_stream_compactor_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit column stream compactor testbench
// Streams column words with keep flags through the compactor under random
// handshake gaps and register settings. A scoreboard predicts every packed
// word, its final mark and its count mismatch flag, and checks each result
// request against the oldest prediction in order.
// ----------------------------------------------------------------------------
module bit_column_stream_compactor_test;

  localparam int WORD_W         = bcsc_pkg::WORD_W;
  localparam int RANDOM_WORDS   = 1200;
  localparam int DRAIN_CYCLES   = 6;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {
    KEEP_RANDOM, KEEP_ALL, KEEP_NONE, KEEP_SPARSE, KEEP_DENSE
  } keep_pattern_t;

  // Scoreboard: mirrors the compactor state and holds the packed words
  // still owed by the block.
  class packed_word_tracker_t;
    int                  live_shots_reg;
    int                  expected_kept_reg;
    logic [WORD_W-1:0]   partial;
    int                  fill;
    int                  position;
    int                  kept;
    bcsc_pkg::result_t   owed_words[$];
    int                  errors;

    function new();
      live_shots_reg    = bcsc_pkg::LIVE_SHOTS_RST;
      expected_kept_reg = bcsc_pkg::EXPECTED_KEPT_RST;
      partial           = '0;
      fill              = 0;
      position          = 0;
      kept              = 0;
      errors            = 0;
    endfunction

    function void set_register(logic [bcsc_pkg::CFG_IDX_W-1:0] idx,
                               logic [bcsc_pkg::CFG_W-1:0] val);
      if (idx == bcsc_pkg::REG_LIVE_SHOTS) begin
        live_shots_reg = val;
      end else if (idx == bcsc_pkg::REG_EXPECTED_KEPT) begin
        expected_kept_reg = val;
      end
    endfunction

    function int owed_count();
      return owed_words.size();
    endfunction

    function void note_column_word(logic [WORD_W-1:0] cw, logic [WORD_W-1:0] kf);
      int                shots;
      int                last_idx;
      bit                is_last;
      logic [WORD_W-1:0] live;
      logic [WORD_W-1:0] keep;
      logic [WORD_W-1:0] ext;
      int                n;
      int                total;
      bit                emitted;
      bit                mism;
      shots = live_shots_reg;
      if (shots < 1) shots = 1;
      if (shots > bcsc_pkg::MAX_SHOTS_DEF) shots = bcsc_pkg::MAX_SHOTS_DEF;
      last_idx = (shots - 1) >> 6;
      is_last  = (position >= last_idx);
      live     = '1;
      if (is_last && (shots % 64) != 0) live = (64'd1 << (shots % 64)) - 64'd1;
      keep = kf & live;
      ext  = '0;
      n    = 0;
      for (int i = 0; i < WORD_W; i++) begin
        if (keep[i]) begin
          ext[n] = cw[i];
          n++;
        end
      end
      kept += n;
      emitted = 1'b0;
      if (n != 0) begin
        total = fill + n;
        if (total >= WORD_W) begin
          owed_words.insert(owed_words.size(),
                            bcsc_pkg::result_t'{packed_word: partial | (ext << fill),
                                                final_word: 1'b0,
                                                count_mismatch: 1'b0});
          emitted = 1'b1;
          partial = (fill == 0) ? '0 : (ext >> (WORD_W - fill));
          fill    = total - WORD_W;
        end else begin
          partial |= ext << fill;
          fill     = total;
        end
      end
      if (!is_last) begin
        position++;
        return;
      end
      mism = (kept != expected_kept_reg);
      if (fill != 0 || !emitted) begin
        owed_words.insert(owed_words.size(),
                          bcsc_pkg::result_t'{packed_word: (fill != 0) ? partial : '0,
                                              final_word: 1'b1,
                                              count_mismatch: mism});
      end else begin
        // The word completed on the last step carries the final mark itself.
        owed_words[owed_words.size()-1].final_word     = 1'b1;
        owed_words[owed_words.size()-1].count_mismatch = mism;
      end
      partial  = '0;
      fill     = 0;
      position = 0;
      kept     = 0;
    endfunction

    function void check_packed_word(logic [WORD_W-1:0] pw, logic fw, logic cm);
      bcsc_pkg::result_t want;
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected result: packed_word %h final_word %b count_mismatch %b",
                 $time, pw, fw, cm);
        errors++;
        return;
      end
      want = owed_words.pop_front();
      if (pw !== want.packed_word) begin
        $display("%0t: packed_word mismatch: expected %h actual %h",
                 $time, want.packed_word, pw);
        errors++;
      end
      if (fw !== want.final_word) begin
        $display("%0t: final_word mismatch: expected %b actual %b",
                 $time, want.final_word, fw);
        errors++;
      end
      if (cm !== want.count_mismatch) begin
        $display("%0t: count_mismatch mismatch: expected %b actual %b",
                 $time, want.count_mismatch, cm);
        errors++;
      end
    endfunction
  endclass

  logic                           clk            = 1'b0;
  logic                           rst            = 1'b1;
  logic                           in_valid       = 1'b0;
  logic                           in_ready;
  logic [WORD_W-1:0]              column_word    = '0;
  logic [WORD_W-1:0]              keep_flags     = '0;
  logic                           out_valid;
  logic                           out_ready      = 1'b0;
  logic [WORD_W-1:0]              packed_word;
  logic                           final_word;
  logic                           count_mismatch;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [bcsc_pkg::CFG_IDX_W-1:0] cfg_index      = bcsc_pkg::REG_LIVE_SHOTS;
  logic [bcsc_pkg::CFG_W-1:0]     cfg_data       = '0;

  packed_word_tracker_t tracker = new();
  bit burst       = 1'b0;
  bit rx_hold_req = 1'b0;
  int words_sent  = 0;

  bit_column_stream_compactor u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .column_word    (column_word),
    .keep_flags     (keep_flags),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .packed_word    (packed_word),
    .final_word     (final_word),
    .count_mismatch (count_mismatch),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_cycles();
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [WORD_W-1:0] rand_keep();
    keep_pattern_t p;
    p = keep_pattern_t'($urandom_range(0, 4));
    unique case (p)
      KEEP_ALL:    return '1;
      KEEP_NONE:   return '0;
      KEEP_SPARSE: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      KEEP_DENSE:  return {$urandom, $urandom} | {$urandom, $urandom};
      default:     return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] last_word_mask(int shots);
    return ((shots % 64) == 0) ? '1 : (64'd1 << (shots % 64)) - 64'd1;
  endfunction

  task automatic send_word(input logic [WORD_W-1:0] cw, input logic [WORD_W-1:0] kf);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    column_word <= cw;
    keep_flags  <= kf;
    do @(posedge clk); while (!in_ready);
    tracker.note_column_word(cw, kf);
    words_sent++;
  endtask

  task automatic write_reg(input logic [bcsc_pkg::CFG_IDX_W-1:0] idx, input int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bcsc_pkg::CFG_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.set_register(idx, bcsc_pkg::CFG_W'(val));
    @(posedge clk);
  endtask

  // Stops offering words and waits until every owed result has arrived,
  // then gives words that produce no result time to leave the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.owed_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result side.
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        gap         = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
      end else begin
        gap = idle_cycles();
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_packed_word(packed_word, final_word, count_mismatch);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : main
    int                start;
    int                r;
    int                shots_cfg;
    int                eff;
    int                wpc;
    int                ncols;
    int                cnt;
    int                exp_cfg;
    logic [WORD_W-1:0] cw_q[$];
    logic [WORD_W-1:0] kf_q[$];

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: one word per column. A full word on the last step,
    // then an empty last step.
    send_word('1, '1);
    send_word(rand_word(), '0);
    wait_idle();
    write_reg(bcsc_pkg::REG_EXPECTED_KEPT, 64);
    send_word('0, '1);

    // Completed word plus a remainder on the last step.
    wait_idle();
    write_reg(bcsc_pkg::REG_LIVE_SHOTS, 128);
    write_reg(bcsc_pkg::REG_EXPECTED_KEPT, 96);
    send_word(rand_word(), 64'h0000_0000_FFFF_FFFF);
    send_word(rand_word(), '1);

    // Partial last word masked down to the live shots.
    wait_idle();
    write_reg(bcsc_pkg::REG_LIVE_SHOTS, 100);
    send_word('1, '1);
    send_word(rand_word(), '1);
    wait_idle();
    write_reg(bcsc_pkg::REG_LIVE_SHOTS, 65);
    send_word(rand_word(), rand_keep());
    send_word('1, '1);

    // Shrinking the column mid-way makes the next word the last one.
    wait_idle();
    write_reg(bcsc_pkg::REG_LIVE_SHOTS, 256);
    send_word(rand_word(), rand_keep());
    send_word(rand_word(), rand_keep());
    wait_idle();
    write_reg(bcsc_pkg::REG_LIVE_SHOTS, 64);
    send_word(rand_word(), rand_keep());

    // Zero live shots counts as one shot.
    wait_idle();
    write_reg(bcsc_pkg::REG_LIVE_SHOTS, 0);
    write_reg(bcsc_pkg::REG_EXPECTED_KEPT, 1);
    send_word(64'h1, '1);
    send_word('1, 64'hFFFF_FFFF_FFFF_FFFE);
    wait_idle();
    write_reg(bcsc_pkg::REG_LIVE_SHOTS, 63);
    write_reg(bcsc_pkg::REG_EXPECTED_KEPT, 8191);
    send_word('1, '1);
    send_word(rand_word(), 64'h8000_0000_0000_0000);

    // Receiver holds off while the sender streams full words back to back.
    wait_idle();
    write_reg(bcsc_pkg::REG_LIVE_SHOTS, 64);
    write_reg(bcsc_pkg::REG_EXPECTED_KEPT, 64);
    burst       = 1'b1;
    rx_hold_req = 1'b1;
    repeat (60) send_word(rand_word(), '1);
    burst = 1'b0;
    wait_idle();

    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 2) shots_cfg = bcsc_pkg::MAX_SHOTS_DEF;
      else if (r < 3) shots_cfg = $urandom_range(bcsc_pkg::MAX_SHOTS_DEF + 1, 8191);
      else if (r < 5) shots_cfg = 0;
      else if (r < 15) shots_cfg = 64 * $urandom_range(1, 4);
      else shots_cfg = $urandom_range(1, 320);
      eff = shots_cfg;
      if (eff < 1) eff = 1;
      if (eff > bcsc_pkg::MAX_SHOTS_DEF) eff = bcsc_pkg::MAX_SHOTS_DEF;
      wpc   = ((eff - 1) >> 6) + 1;
      ncols = (wpc > 8) ? 1 : $urandom_range(1, 6);
      cw_q.delete();
      kf_q.delete();
      for (int i = 0; i < ncols * wpc; i++) begin
        cw_q.insert(cw_q.size(), rand_word());
        kf_q.insert(kf_q.size(), rand_keep());
      end
      cnt = 0;
      for (int w = 0; w < wpc; w++) begin
        cnt += $countones(kf_q[w] & ((w == wpc - 1) ? last_word_mask(eff) : '1));
      end
      // Now and then the last column is cut short so the next setting
      // lands in the middle of a column.
      if (wpc > 1 && $urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, wpc - 1)) begin
          void'(cw_q.pop_back());
          void'(kf_q.pop_back());
        end
      end
      r = $urandom_range(0, 3);
      if (r < 2) exp_cfg = cnt;
      else if (r == 2) exp_cfg = $urandom_range(0, bcsc_pkg::MAX_SHOTS_DEF);
      else exp_cfg = ($urandom_range(0, 1) == 1) ? 8191 : 0;
      if ($urandom_range(0, 1) == 1) begin
        write_reg(bcsc_pkg::REG_LIVE_SHOTS, shots_cfg);
        write_reg(bcsc_pkg::REG_EXPECTED_KEPT, exp_cfg);
      end else begin
        write_reg(bcsc_pkg::REG_EXPECTED_KEPT, exp_cfg);
        write_reg(bcsc_pkg::REG_LIVE_SHOTS, shots_cfg);
      end
      burst = ($urandom_range(0, 4) == 0);
      foreach (cw_q[i]) send_word(cw_q[i], kf_q[i]);
      burst = 1'b0;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/bcsc_pkg.sv
hw/rtl/bcsc_cfg_regs.sv
hw/rtl/bcsc_pext.sv
hw/rtl/bcsc_packer.sv
hw/rtl/bcsc_out_fifo.sv
hw/rtl/bit_column_stream_compactor.sv
hw/rtl/bcsc_checker.sv
tb/bit_column_stream_compactor_test.sv
